>>> rtl/ffve_pkg.sv
package ffve_pkg;

	localparam int MAX_VALUE_BYTES_DEF = 1024;

	localparam int BYTE_W   = 8;
	localparam int KEY_CHARS_W = 64;
	localparam int KEY_LEN_W   = 4;
	localparam int CAP_W       = 11;
	localparam int CFG_IDX_W   = 2;

	localparam logic [KEY_LEN_W-1:0] KEY_MAX_LEN = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAP  = 2'd2;

	localparam logic [CAP_W-1:0] VALUE_CAP_RESET = 11'd64;

	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
	localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
	localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_ERROR     = 2'd2;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] value;
		logic [1:0]        status;
		logic              last;
	} result_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
		logic [4:0] d;
		d = 5'h10;
		if (c >= 8'h30 && c <= 8'h39)
			d = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66)
			d = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46)
			d = 5'(c - 8'h37);
		return d;
	endfunction

endpackage

>>> rtl/form_field_value_extractor.sv
// channel   | handshake                  | payload
// body      | body_valid / body_stall    | body_byte, end_of_body
// result    | result_valid / result_stall| result_kind, value_byte, status, last
// config    | cfg_write_en               | cfg_index, cfg_data
//
// One body byte per cycle while body_stall is low: input register, combinational decode, 4-entry result queue.
// An item yields up to two results; the queue drains one result per cycle while result_stall is low.
// An accepted byte passes through the input register and then the result queue before its result is offered.
// body_stall rises while the input register holds an item and the queue has under two free slots.
// arst_n clears control state, empties the queue and resets the config registers (capacity to 64).
module form_field_value_extractor import ffve_pkg::*; #(
	parameter int MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   body_valid,
	output logic                   body_stall,
	input  logic [BYTE_W-1:0]      body_byte,
	input  logic                   end_of_body,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   result_kind,
	output logic [BYTE_W-1:0]      value_byte,
	output logic [1:0]             status,
	output logic                   last,
	input  logic                   cfg_write_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [KEY_CHARS_W-1:0] cfg_data
);

	localparam logic [1:0] PH_KEY   = 2'd0;
	localparam logic [1:0] PH_SKIP  = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam int MaxCapInt = (MAX_VALUE_BYTES > 2047) ? 2047 : MAX_VALUE_BYTES;
	localparam logic [CAP_W-1:0] MaxCap = CAP_W'(MaxCapInt);

	localparam int QDepth = 4;
	localparam int QPtrW  = 2;
	localparam int QCntW  = 3;

	logic [KEY_CHARS_W-1:0] key_chars_q;
	logic [KEY_LEN_W-1:0]   key_length_q;
	logic [CAP_W-1:0]       value_capacity_q;

	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic                   eob_s1;

	logic [1:0]             phase_q, phase_d;
	logic [KEY_LEN_W-1:0]   key_position_q, key_position_d;
	logic                   key_mismatch_q, key_mismatch_d;
	logic [1:0]             escape_step_q, escape_step_d;
	logic [3:0]             high_nibble_q, high_nibble_d;
	logic [CAP_W-1:0]       value_count_q, value_count_d;
	logic                   decode_error_q, decode_error_d;

	result_t                queue_q [QDepth];
	logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0]       count_q;

	logic                   body_take;
	logic                   advance;
	logic                   result_take;
	logic                   body_end;
	logic                   emit_byte;
	logic [BYTE_W-1:0]      emit_value;
	logic [1:0]             end_status;
	logic [KEY_LEN_W-1:0]   klen;
	logic [CAP_W-1:0]       cap_eff;
	logic [BYTE_W-1:0]      key_char;
	logic [4:0]             digit;
	logic [BYTE_W-1:0]      cand;
	logic                   cand_valid;
	logic [1:0]             n_push;
	result_t                push0, push1;

	assign body_take   = body_valid && !body_stall;
	assign advance     = valid_s1 && (count_q <= QCntW'(QDepth - 2));
	assign body_stall  = valid_s1 && !advance;
	assign result_take = result_valid && !result_stall;

	assign klen     = (key_length_q > KEY_MAX_LEN) ? KEY_MAX_LEN : key_length_q;
	assign cap_eff  = (value_capacity_q > MaxCap) ? MaxCap : value_capacity_q;
	assign key_char = key_chars_q[{key_position_q[2:0], 3'b000} +: BYTE_W];
	assign digit    = hex_digit(byte_s1);
	assign body_end = (byte_s1 == CH_NUL) || eob_s1;

	always_comb begin
		phase_d        = phase_q;
		key_position_d = key_position_q;
		key_mismatch_d = key_mismatch_q;
		escape_step_d  = escape_step_q;
		high_nibble_d  = high_nibble_q;
		value_count_d  = value_count_q;
		decode_error_d = decode_error_q;
		cand           = byte_s1;
		cand_valid     = 1'b0;
		emit_byte      = 1'b0;
		emit_value     = byte_s1;
		end_status     = ST_OK;

		if (byte_s1 != CH_NUL) begin
			unique case (phase_q)
				PH_KEY: begin
					if (byte_s1 == CH_AMP) begin
						key_position_d = '0;
						key_mismatch_d = 1'b0;
					end else if (byte_s1 == CH_EQ) begin
						phase_d = (!key_mismatch_q && key_position_q == klen) ? PH_VALUE : PH_SKIP;
					end else if (key_position_q < klen && byte_s1 == key_char) begin
						key_position_d = key_position_q + 1'b1;
					end else begin
						key_mismatch_d = 1'b1;
					end
				end
				PH_SKIP: begin
					if (byte_s1 == CH_AMP) begin
						phase_d        = PH_KEY;
						key_position_d = '0;
						key_mismatch_d = 1'b0;
					end
				end
				PH_VALUE: begin
					if (escape_step_q == ESC_HIGH) begin
						if (digit[4]) begin
							decode_error_d = 1'b1;
							phase_d        = PH_DONE;
						end else begin
							high_nibble_d = digit[3:0];
							escape_step_d = ESC_LOW;
						end
					end else if (escape_step_q == ESC_LOW) begin
						escape_step_d = ESC_NONE;
						if (digit[4]) begin
							decode_error_d = 1'b1;
							phase_d        = PH_DONE;
						end else begin
							cand       = {high_nibble_q, digit[3:0]};
							cand_valid = 1'b1;
						end
					end else if (byte_s1 == CH_AMP) begin
						phase_d = PH_DONE;
					end else if (byte_s1 == CH_PCT) begin
						escape_step_d = ESC_HIGH;
					end else if (byte_s1 == CH_PLUS) begin
						cand       = CH_SPACE;
						cand_valid = 1'b1;
					end else begin
						cand_valid = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (cand_valid) begin
			if (cand < CH_SPACE || cand == CH_DEL ||
			    ({1'b0, value_count_q} + 1'b1) >= {1'b0, cap_eff}) begin
				decode_error_d = 1'b1;
				phase_d        = PH_DONE;
			end else begin
				emit_byte     = 1'b1;
				emit_value    = cand;
				value_count_d = value_count_q + 1'b1;
			end
		end

		if (phase_d == PH_KEY || phase_d == PH_SKIP)
			end_status = ST_NOT_FOUND;
		else if (decode_error_d || escape_step_d != ESC_NONE)
			end_status = ST_ERROR;
		else
			end_status = ST_OK;

		if (body_end) begin
			phase_d        = PH_KEY;
			key_position_d = '0;
			key_mismatch_d = 1'b0;
			escape_step_d  = ESC_NONE;
			high_nibble_d  = '0;
			value_count_d  = '0;
			decode_error_d = 1'b0;
		end
	end

	always_comb begin
		push0 = '{kind: KIND_BYTE, value: emit_value, status: ST_OK, last: 1'b0};
		push1 = '{kind: KIND_STATUS, value: CH_NUL, status: end_status, last: 1'b1};
		n_push = '0;
		if (advance) begin
			if (emit_byte && body_end)
				n_push = 2'd2;
			else if (emit_byte)
				n_push = 2'd1;
			else if (body_end) begin
				n_push = 2'd1;
				push0  = push1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q      <= '0;
			key_length_q     <= '0;
			value_capacity_q <= VALUE_CAP_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_KEY_CHARS:  key_chars_q      <= cfg_data;
				CFG_KEY_LENGTH: key_length_q     <= cfg_data[KEY_LEN_W-1:0];
				CFG_VALUE_CAP:  value_capacity_q <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (body_take) begin
			byte_s1 <= body_byte;
			eob_s1  <= end_of_body;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_KEY;
			key_position_q <= '0;
			key_mismatch_q <= 1'b0;
			escape_step_q  <= ESC_NONE;
			high_nibble_q  <= '0;
			value_count_q  <= '0;
			decode_error_q <= 1'b0;
		end else if (advance) begin
			phase_q        <= phase_d;
			key_position_q <= key_position_d;
			key_mismatch_q <= key_mismatch_d;
			escape_step_q  <= escape_step_d;
			high_nibble_q  <= high_nibble_d;
			value_count_q  <= value_count_d;
			decode_error_q <= decode_error_d;
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			queue_q[wr_ptr_q] <= push0;
		if (n_push == 2'd2)
			queue_q[wr_ptr_q + 1'b1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
			if (result_take)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QCntW'(n_push) - QCntW'(result_take);
		end
	end

	assign result_valid = (count_q != '0);
	assign result_kind  = queue_q[rd_ptr_q].kind;
	assign value_byte   = queue_q[rd_ptr_q].value;
	assign status       = queue_q[rd_ptr_q].status;
	assign last         = queue_q[rd_ptr_q].last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("result queue overrun");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && body_end |=> phase_q == PH_KEY && value_count_q == '0 && !decode_error_q)
		else $error("body state not cleared at end of body");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		value_count_q == '0 || value_count_q < cap_eff)
		else $error("value count reached capacity");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		body_stall |-> valid_s1 && count_q > QCntW'(QDepth - 2))
		else $error("input stalled without cause");

endmodule

>>> tb/sv/form_field_value_extractor_test.sv
`timescale 1ns / 100ps

module form_field_value_extractor_test;
	import ffve_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 12;
	localparam int ITEMS_PER_SETTING = 62;
	localparam int REPORT_LINES = 40;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {SCAN_KEY, SCAN_SKIP, SCAN_VALUE, SCAN_DONE} scan_phase_e;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_e;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   body_valid = 1'b0;
	logic                   body_stall;
	logic [BYTE_W-1:0]      body_byte = '0;
	logic                   end_of_body = 1'b0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic                   result_kind;
	logic [BYTE_W-1:0]      value_byte;
	logic [1:0]             status;
	logic                   last;
	logic                   cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [KEY_CHARS_W-1:0] cfg_data = '0;

	// register copies
	logic [KEY_CHARS_W-1:0] key_bytes_m = '0;
	logic [KEY_LEN_W-1:0]   key_len_m = '0;
	logic [CAP_W-1:0]       capacity_m = VALUE_CAP_RESET;

	// body state of the predictor
	scan_phase_e      scan_m = SCAN_KEY;
	logic [3:0]       key_pos_m = '0;
	logic             key_miss_m = 1'b0;
	logic [1:0]       esc_m = ESC_NONE;
	logic [3:0]       hi_nib_m = '0;
	logic [CAP_W-1:0] count_m = '0;
	logic             err_m = 1'b0;

	result_t results_due[$];

	int mismatches = 0;
	int items_sent = 0;
	int gap_max = 0;
	int burst_left = 0;
	int hold_request = 0;
	int hold_left = 0;
	int stall_tick = 0;
	int quiet_cycles = 0;
	stall_mode_e stall_mode = STALL_NONE;

	form_field_value_extractor uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.body_valid   (body_valid),
		.body_stall   (body_stall),
		.body_byte    (body_byte),
		.end_of_body  (end_of_body),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.value_byte   (value_byte),
		.status       (status),
		.last         (last),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic result_t make_result(logic kind, logic [BYTE_W-1:0] v, logic [1:0] st,
			logic fin);
		result_t r;
		r.kind = kind;
		r.value = v;
		r.status = st;
		r.last = fin;
		return r;
	endfunction

	// bit 4 flags a non-hex character
	function automatic logic [4:0] hex_nibble(logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] folded;
		folded = c | 8'h20;
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b0, c[3:0]};
		if (folded >= 8'h61 && folded <= 8'h66)
			return 5'(folded - 8'h57);
		return 5'h10;
	endfunction

	function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] n, bit upper);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return (upper ? 8'h37 : 8'h57) + 8'(n);
	endfunction

	task automatic start_new_body();
		scan_m = SCAN_KEY;
		key_pos_m = '0;
		key_miss_m = 1'b0;
		esc_m = ESC_NONE;
		hi_nib_m = '0;
		count_m = '0;
		err_m = 1'b0;
	endtask

	task automatic mark_decode_error();
		err_m = 1'b1;
		scan_m = SCAN_DONE;
	endtask

	task automatic take_value_byte(logic [BYTE_W-1:0] v);
		logic [CAP_W-1:0] cap;
		cap = (capacity_m > MAX_VALUE_BYTES_DEF) ? CAP_W'(MAX_VALUE_BYTES_DEF) : capacity_m;
		if (v < CH_SPACE || v == CH_DEL || count_m + 1 >= cap) begin
			mark_decode_error();
		end else begin
			results_due.push_back(make_result(KIND_BYTE, v, ST_OK, 1'b0));
			count_m++;
		end
	endtask

	task automatic decode_body_byte(logic [BYTE_W-1:0] b, logic eob);
		logic [3:0] klen;
		logic [4:0] d;
		logic [1:0] st;
		klen = (key_len_m > KEY_MAX_LEN) ? KEY_MAX_LEN : key_len_m;
		if (b != CH_NUL) begin
			case (scan_m)
				SCAN_KEY: begin
					if (b == CH_AMP) begin
						key_pos_m = '0;
						key_miss_m = 1'b0;
					end else if (b == CH_EQ) begin
						scan_m = (!key_miss_m && key_pos_m == klen) ? SCAN_VALUE : SCAN_SKIP;
					end else if (key_pos_m < klen && b == key_bytes_m[8*key_pos_m +: 8]) begin
						key_pos_m++;
					end else begin
						key_miss_m = 1'b1;
					end
				end
				SCAN_SKIP: begin
					if (b == CH_AMP) begin
						scan_m = SCAN_KEY;
						key_pos_m = '0;
						key_miss_m = 1'b0;
					end
				end
				SCAN_VALUE: begin
					if (esc_m == ESC_HIGH) begin
						d = hex_nibble(b);
						if (d[4]) begin
							mark_decode_error();
						end else begin
							hi_nib_m = d[3:0];
							esc_m = ESC_LOW;
						end
					end else if (esc_m == ESC_LOW) begin
						d = hex_nibble(b);
						esc_m = ESC_NONE;
						if (d[4])
							mark_decode_error();
						else
							take_value_byte({hi_nib_m, d[3:0]});
					end else if (b == CH_AMP) begin
						scan_m = SCAN_DONE;
					end else if (b == CH_PCT) begin
						esc_m = ESC_HIGH;
					end else if (b == CH_PLUS) begin
						take_value_byte(CH_SPACE);
					end else begin
						take_value_byte(b);
					end
				end
				default: begin
				end
			endcase
		end
		if (b == CH_NUL || eob) begin
			if (scan_m == SCAN_KEY || scan_m == SCAN_SKIP)
				st = ST_NOT_FOUND;
			else if (err_m || esc_m != ESC_NONE)
				st = ST_ERROR;
			else
				st = ST_OK;
			results_due.push_back(make_result(KIND_STATUS, CH_NUL, st, 1'b1));
			start_new_body();
		end
	endtask

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : check_results
		result_t due;
		if (arst_n && result_valid && !result_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with nothing due",
					16'({result_kind, value_byte, status, last}), '0);
			end else begin
				due = results_due.pop_front();
				if (result_kind !== due.kind)
					report_mismatch("result_kind", 16'(result_kind), 16'(due.kind));
				if (value_byte !== due.value)
					report_mismatch("value_byte", 16'(value_byte), 16'(due.value));
				if (status !== due.status)
					report_mismatch("status", 16'(status), 16'(due.status));
				if (last !== due.last)
					report_mismatch("last", 16'(last), 16'(due.last));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		stall_tick++;
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:   result_stall <= 1'b0;
				STALL_LIGHT:  result_stall <= ($urandom_range(99) < 25);
				STALL_HEAVY:  result_stall <= ($urandom_range(99) < 70);
				STALL_BURSTY: result_stall <= ((stall_tick % 13) < 5);
				default:      result_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((body_valid && !body_stall) || (result_valid && !result_stall) || cfg_write_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("form_field_value_extractor_test: FAIL");
			$finish;
		end
	end

	task automatic send_item(logic [BYTE_W-1:0] b, logic eob);
		int gap;
		body_byte <= b;
		end_of_body <= eob;
		body_valid <= 1'b1;
		do
			@(posedge clk);
		while (body_stall);
		decode_body_byte(b, eob);
		items_sent++;
		if (gap_max > 0) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(16, 1);
				gap = $urandom_range(gap_max, 1);
				body_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_text(string s, bit eob_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], eob_last && i == s.len() - 1);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [KEY_CHARS_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_write_en <= 1'b1;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_KEY_CHARS:  key_bytes_m = data;
			CFG_KEY_LENGTH: key_len_m = data[KEY_LEN_W-1:0];
			CFG_VALUE_CAP:  capacity_m = data[CAP_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic settle();
		body_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_value_chunk(ref logic [BYTE_W-1:0] text[$]);
		int r;
		logic [BYTE_W-1:0] c;
		logic [7:0] code;
		r = $urandom_range(99);
		c = 8'($urandom_range(8'h7E, 8'h21));
		if (c == CH_AMP || c == CH_PCT)
			c = 8'h7A;
		code = 8'($urandom);
		if (r < 50) begin
			text.push_back(c);
		end else if (r < 62) begin
			text.push_back(CH_PLUS);
		end else if (r < 82) begin
			text.push_back(CH_PCT);
			text.push_back(hex_char(code[7:4], 1'($urandom_range(1))));
			text.push_back(hex_char(code[3:0], 1'($urandom_range(1))));
		end else if (r < 88) begin
			text.push_back(8'($urandom_range(8'hFF, 8'h80)));
		end else if (r < 91) begin
			text.push_back($urandom_range(1) ? CH_DEL : 8'($urandom_range(8'h1F, 8'h01)));
		end else if (r < 94) begin
			// bad escape: non-hex in either digit slot
			text.push_back(CH_PCT);
			if ($urandom_range(1))
				text.push_back(hex_char(code[3:0], 1'b0));
			text.push_back($urandom_range(1) ? CH_AMP : 8'h67);
		end else if (r < 97) begin
			text.push_back(CH_PCT);
		end else begin
			text.push_back(CH_SPACE);
		end
	endtask

	task automatic send_form_body();
		logic [BYTE_W-1:0] text[$];
		logic [3:0] klen;
		int fields;
		int pick;
		int n;
		bit eob_last;
		klen = (key_len_m > KEY_MAX_LEN) ? KEY_MAX_LEN : key_len_m;
		fields = $urandom_range(3, 1);
		for (int f = 0; f < fields; f++) begin
			if (f > 0)
				text.push_back(CH_AMP);
			pick = $urandom_range(9);
			if (pick < 6) begin
				for (int i = 0; i < klen; i++)
					text.push_back(key_bytes_m[8*i +: 8]);
			end else if (pick < 8) begin
				n = $urandom_range(klen);
				for (int i = 0; i < n; i++)
					text.push_back(key_bytes_m[8*i +: 8]);
				if (pick == 6)
					text.push_back(8'($urandom_range(8'h7A, 8'h61)));
			end else begin
				repeat ($urandom_range(3)) text.push_back(8'($urandom_range(8'h7A, 8'h61)));
			end
			if ($urandom_range(9) != 0) begin
				text.push_back(CH_EQ);
				repeat ($urandom_range(8)) push_value_chunk(text);
			end
		end
		eob_last = $urandom_range(1) && text.size() != 0;
		for (int i = 0; i < text.size(); i++)
			send_item(text[i], eob_last && i == text.size() - 1);
		if (!eob_last)
			send_item(CH_NUL, 1'($urandom_range(1)));
	endtask

	task automatic send_noise_body();
		repeat ($urandom_range(12, 1)) send_item(8'($urandom), $urandom_range(9) == 0);
		send_item(8'($urandom), 1'b1);
	endtask

	task automatic test_directed_cases();
		stall_mode = STALL_NONE;
		gap_max = 0;
		write_register(CFG_KEY_CHARS, 64'h6261);
		write_register(CFG_KEY_LENGTH, 64'd2);
		write_register(CFG_VALUE_CAP, 64'd64);
		// lower-case hex escape, high byte, plus as space, end flag on content
		send_text("ab=%4a", 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_PLUS, 1'b1);
		// field without '=' then a bad escape
		send_text("q&ab=%g", 1'b1);
		// escape cut short by the zero terminator
		send_text("ab=%4", 1'b0);
		send_item(CH_NUL, 1'b0);
		send_text("ab=", 1'b0);
		send_item(CH_DEL, 1'b1);
		send_item(CH_NUL, 1'b1);
		settle();
		write_register(CFG_KEY_LENGTH, 64'd0);
		write_register(CFG_VALUE_CAP, 64'd1);
		write_register(CFG_UNUSED, '1);
		// empty key: overflow at capacity one, then an empty value
		send_text("=x", 1'b1);
		send_text("=", 1'b1);
		settle();
	endtask

	task automatic test_result_backpressure();
		logic [BYTE_W-1:0] c;
		stall_mode = STALL_NONE;
		gap_max = 0;
		write_register(CFG_KEY_CHARS, 64'h6B);
		write_register(CFG_KEY_LENGTH, 64'd1);
		write_register(CFG_VALUE_CAP, 64'd64);
		hold_request = 150;
		send_text("k=", 1'b0);
		repeat (40) begin
			c = 8'($urandom_range(8'h7E, 8'h21));
			if (c == CH_AMP || c == CH_PCT)
				c = CH_PLUS;
			send_item(c, 1'b0);
		end
		send_item(CH_NUL, 1'b0);
		settle();
	endtask

	task automatic test_random_forms();
		logic [KEY_CHARS_W-1:0] key;
		logic [CAP_W-1:0] cap;
		logic [KEY_LEN_W-1:0] klen;
		int first;
		for (int s = 0; s < 8; s++) begin
			for (int i = 0; i < 8; i++)
				key[8*i +: 8] = 8'($urandom_range(8'h64, 8'h61));
			if (s == 3)
				key = '1;
			case (s)
				0: klen = 4'd0;
				1: klen = 4'd8;
				2: klen = 4'd15;
				default: klen = 4'($urandom_range(15));
			endcase
			case (s)
				0: cap = 11'd64;
				1: cap = 11'd1024;
				2: cap = 11'd2047;
				3: cap = 11'd0;
				4: cap = 11'd1;
				5: cap = 11'd2;
				6: cap = 11'($urandom_range(12, 3));
				default: cap = 11'($urandom_range(2047));
			endcase
			write_register(CFG_KEY_CHARS, key);
			write_register(CFG_KEY_LENGTH, 64'(klen));
			write_register(CFG_VALUE_CAP, 64'(cap));
			stall_mode = stall_mode_e'(s % 4);
			gap_max = (s % 3 == 0) ? 0 : $urandom_range(8, 2);
			first = items_sent;
			while (items_sent - first < ITEMS_PER_SETTING) begin
				if ($urandom_range(9) == 0)
					send_noise_body();
				else
					send_form_body();
			end
			settle();
		end
	endtask

	task automatic finish_run();
		settle();
		if (mismatches == 0)
			$display("form_field_value_extractor_test: PASS");
		else
			$display("form_field_value_extractor_test: FAIL");
		$finish;
	endtask

	initial begin
		do
			@(posedge clk);
		while (!arst_n);
		@(posedge clk);
		test_directed_cases();
		test_result_backpressure();
		test_random_forms();
		finish_run();
	end

endmodule

>>> sim.f
rtl/ffve_pkg.sv
rtl/form_field_value_extractor.sv
tb/sv/form_field_value_extractor_test.sv
